### sv/eps_pkg.sv
// ----------------------------------------------------------------------------
// eps_pkg
// shared widths, codes and types of the encoder period speed meter
// ----------------------------------------------------------------------------
package eps_pkg;

  localparam int CHANNELS   = 3;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_FIELD_W = 2;
  localparam int CH_EXT_W   = 4;

  localparam int NUM_W      = 24;
  localparam int PERIOD_W   = 16;
  localparam int SPEED_W    = 25;
  localparam int POS_W      = 32;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  localparam logic [NUM_W-1:0]    NUM_RESET     = 24'd2000000;
  localparam logic [PERIOD_W-1:0] TIMEOUT_RESET = 16'hFFFF;

  // transaction kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

  // controls from the sequencer to the channel bank
  typedef struct packed {
    logic                  tick;
    logic                  upd;
    logic                  rev;
    logic [CH_FIELD_W-1:0] ch;
  } bank_ctrl_t;

  function automatic logic ch_in_range(input logic [CH_FIELD_W-1:0] ch);
    return CH_EXT_W'(ch) < CH_EXT_W'(CHANNELS);
  endfunction

endpackage

### sv/eps_channel_if.sv
// ----------------------------------------------------------------------------
// eps channel interfaces
// valid/ready channels for edge/tick transactions and speed reports
// ----------------------------------------------------------------------------
interface eps_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [eps_pkg::CH_FIELD_W-1:0]    channel;
  logic                              direction_reverse;

  modport source (output valid, output cmd, output channel, output direction_reverse,
                  input ready);
  modport sink   (input valid, input cmd, input channel, input direction_reverse,
                  output ready);
endinterface

interface eps_out_if;
  logic                              valid;
  logic                              ready;
  logic [eps_pkg::CH_FIELD_W-1:0]    report_channel;
  logic signed [eps_pkg::SPEED_W-1:0] speed_q16;
  logic signed [eps_pkg::POS_W-1:0]  position;
  logic [eps_pkg::MASK_W-1:0]        stopped_mask;

  modport source (output valid, output report_channel, output speed_q16,
                  output position, output stopped_mask, input ready);
  modport sink   (input valid, input report_channel, input speed_q16,
                  input position, input stopped_mask, output ready);
endinterface

### sv/encoder_period_speed_meter.sv
// ----------------------------------------------------------------------------
// encoder_period_speed_meter
// period-based speed and position of encoder channels on a shared timebase
// path: a tick goes from acceptance through S_WB into the output register;
//   an edge goes through S_DIV (the bit-serial divider), S_UPD and S_WB,
//   skipping S_DIV when the period is zero or the channel is out of range
// flow: one transaction in work at a time, the next is taken the cycle
//   after its report loads, and S_WB waits while the output is stalled
// reset (rst_n low, synchronous): counters, positions and speeds clear,
//   registers return to numerator 2000000 and timeout 65535
// ----------------------------------------------------------------------------
module encoder_period_speed_meter (
  input  logic                              clk,
  input  logic                              rst_n,
  eps_in_if.sink                            in_chan,
  eps_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,   // waiting for a transaction
    S_DIV  = 4'b0010,   // serial divide in progress
    S_UPD  = 4'b0100,   // write the edge result into the bank
    S_WB   = 4'b1000    // move the report into the output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [eps_pkg::NUM_W-1:0]    num_r;
  logic [eps_pkg::PERIOD_W-1:0] tmo_r;

  // captured transaction
  logic                              cmd_r;
  logic [eps_pkg::CH_FIELD_W-1:0]    ch_r;
  logic                              rev_r;
  logic                              use_div_r;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic [eps_pkg::CH_FIELD_W-1:0]    rpt_ch_r;
  logic signed [eps_pkg::SPEED_W-1:0] rpt_spd_r;
  logic signed [eps_pkg::POS_W-1:0]  rpt_pos_r;
  logic [eps_pkg::MASK_W-1:0]        rpt_mask_r;

  logic                              in_acc;
  logic                              is_edge;
  logic                              out_free;
  logic                              out_load;
  logic                              div_start;
  logic                              div_done;
  logic [eps_pkg::NUM_W-1:0]         div_quo;
  logic [eps_pkg::NUM_W-1:0]         mag;
  logic [eps_pkg::CH_FIELD_W-1:0]    rd_ch;

  eps_pkg::bank_ctrl_t               bank_ctrl;
  logic                              rd_valid;
  logic [eps_pkg::PERIOD_W-1:0]      rd_period;
  logic signed [eps_pkg::SPEED_W-1:0] rd_speed;
  logic signed [eps_pkg::POS_W-1:0]  rd_position;
  logic [eps_pkg::MASK_W-1:0]        stop_mask;

  // handshakes
  assign in_chan.ready = state_r == S_IDLE;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_edge       = in_chan.cmd == eps_pkg::CMD_EDGE;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign out_load      = (state_r == S_WB) && out_free;

  // the bank is read at the incoming channel while idle, else at the held one
  assign rd_ch = (state_r == S_IDLE) ? in_chan.channel : ch_r;

  // a tick updates the bank on the accepting edge; an edge waits for its speed
  assign bank_ctrl.tick = in_acc && !is_edge;
  assign bank_ctrl.upd  = (state_r == S_UPD) && (cmd_r == eps_pkg::CMD_EDGE);
  assign bank_ctrl.rev  = rev_r;
  assign bank_ctrl.ch   = rd_ch;

  // a zero period takes the numerator itself, so no divide is started
  assign div_start = in_acc && is_edge && rd_valid && (rd_period != '0);
  assign mag       = use_div_r ? div_quo : num_r;

  eps_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (rd_period),
    .done     (div_done),
    .quotient (div_quo)
  );

  eps_channel_bank u_bank (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (bank_ctrl),
    .mag         (mag),
    .timeout     (tmo_r),
    .rd_valid    (rd_valid),
    .rd_period   (rd_period),
    .rd_speed    (rd_speed),
    .rd_position (rd_position),
    .stop_mask   (stop_mask)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_edge) begin
            state_nxt = S_WB;
          end else if (div_start) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid clears on a taken transaction, sets on a load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      num_r       <= eps_pkg::NUM_RESET;
      tmo_r       <= eps_pkg::TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          eps_pkg::CFG_NUMERATOR: num_r <= cfg_wdata;
          eps_pkg::CFG_TIMEOUT:   tmo_r <= cfg_wdata[eps_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_chan.cmd;
      ch_r      <= in_chan.channel;
      rev_r     <= in_chan.direction_reverse;
      use_div_r <= div_start;
    end
  end

  // report payload, read back from the bank after its update
  always_ff @(posedge clk) begin
    if (out_load) begin
      rpt_ch_r   <= ch_r;
      rpt_spd_r  <= rd_speed;
      rpt_pos_r  <= rd_position;
      rpt_mask_r <= (cmd_r == eps_pkg::CMD_TICK) ? stop_mask : '0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.report_channel = rpt_ch_r;
  assign out_chan.speed_q16      = rpt_spd_r;
  assign out_chan.position       = rpt_pos_r;
  assign out_chan.stopped_mask   = rpt_mask_r;

endmodule

### sv/eps_divider.sv
// ----------------------------------------------------------------------------
// eps_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module eps_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [eps_pkg::NUM_W-1:0]     dividend,
  input  logic [eps_pkg::PERIOD_W-1:0]  divisor,
  output logic                          done,
  output logic [eps_pkg::NUM_W-1:0]     quotient
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [eps_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [eps_pkg::PERIOD_W-1:0]     rem_r, rem_nxt;
  logic [eps_pkg::NUM_W-1:0]        quo_r, quo_nxt;
  logic [eps_pkg::PERIOD_W-1:0]     dvs_r, dvs_nxt;

  logic [eps_pkg::PERIOD_W:0]       trial;
  logic [eps_pkg::PERIOD_W:0]       diff;
  logic                             fits;
  logic                             last;

  // shift in the next dividend bit, subtract when it fits
  assign trial = {rem_r, quo_r[eps_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};
  assign last  = cnt_r == eps_pkg::DIV_CNT_W'(eps_pkg::NUM_W - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[eps_pkg::PERIOD_W-1:0] : trial[eps_pkg::PERIOD_W-1:0];
      quo_nxt = {quo_r[eps_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r + eps_pkg::DIV_CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/eps_channel_bank.sv
// ----------------------------------------------------------------------------
// eps_channel_bank
// per-channel period counters, positions and speeds
// ----------------------------------------------------------------------------
module eps_channel_bank (
  input  logic                                clk,
  input  logic                                rst_n,
  input  eps_pkg::bank_ctrl_t                 ctrl,
  input  logic [eps_pkg::NUM_W-1:0]           mag,
  input  logic [eps_pkg::PERIOD_W-1:0]        timeout,
  output logic                                rd_valid,
  output logic [eps_pkg::PERIOD_W-1:0]        rd_period,
  output logic signed [eps_pkg::SPEED_W-1:0]  rd_speed,
  output logic signed [eps_pkg::POS_W-1:0]    rd_position,
  output logic [eps_pkg::MASK_W-1:0]          stop_mask
);

  logic [eps_pkg::PERIOD_W-1:0]       cnt_r [eps_pkg::CHANNELS];
  logic signed [eps_pkg::POS_W-1:0]   pos_r [eps_pkg::CHANNELS];
  logic signed [eps_pkg::SPEED_W-1:0] spd_r [eps_pkg::CHANNELS];
  logic [eps_pkg::MASK_W-1:0]         stop_r, stop_nxt;

  logic [eps_pkg::CHANNELS-1:0]       wrap;
  logic [eps_pkg::CH_EXT_W-1:0]       ch_ext;
  logic [eps_pkg::CH_IDX_W-1:0]       idx;
  logic signed [eps_pkg::SPEED_W-1:0] mag_s;

  assign ch_ext   = eps_pkg::CH_EXT_W'(ctrl.ch);
  assign idx      = ch_ext[eps_pkg::CH_IDX_W-1:0];
  assign rd_valid = eps_pkg::ch_in_range(ctrl.ch);
  assign mag_s    = $signed(eps_pkg::SPEED_W'(mag));

  for (genvar c = 0; c < eps_pkg::CHANNELS; c++) begin : g_wrap
    assign wrap[c] = cnt_r[c] >= timeout;
  end

  // only the first three channels have a stop flag
  for (genvar c = 0; c < eps_pkg::MASK_W; c++) begin : g_stop
    if (c < eps_pkg::CHANNELS) begin : g_on
      assign stop_nxt[c] = wrap[c];
    end else begin : g_off
      assign stop_nxt[c] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < eps_pkg::CHANNELS; c++) begin
        cnt_r[c] <= '0;
        pos_r[c] <= '0;
        spd_r[c] <= '0;
      end
    end else if (ctrl.tick) begin
      for (int c = 0; c < eps_pkg::CHANNELS; c++) begin
        if (wrap[c]) begin
          cnt_r[c] <= '0;
          spd_r[c] <= '0;
        end else begin
          cnt_r[c] <= cnt_r[c] + eps_pkg::PERIOD_W'(1);
        end
      end
    end else if (ctrl.upd && rd_valid) begin
      cnt_r[idx] <= '0;
      spd_r[idx] <= ctrl.rev ? -mag_s : mag_s;
      pos_r[idx] <= ctrl.rev ? pos_r[idx] - eps_pkg::POS_W'(1)
                             : pos_r[idx] + eps_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick) begin
      stop_r <= stop_nxt;
    end
  end

  assign rd_period   = rd_valid ? cnt_r[idx] : '0;
  assign rd_speed    = rd_valid ? spd_r[idx] : '0;
  assign rd_position = rd_valid ? pos_r[idx] : '0;
  assign stop_mask   = stop_r;

endmodule

### sv/eps_checker.sv
// ----------------------------------------------------------------------------
// eps_checker
// port-level checks of the encoder period speed meter
// ----------------------------------------------------------------------------
module eps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_cmd,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [eps_pkg::CH_FIELD_W-1:0]    out_report_channel,
  input logic signed [eps_pkg::SPEED_W-1:0] out_speed_q16,
  input logic signed [eps_pkg::POS_W-1:0]  out_position
);

  // a stalled report stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("report dropped while stalled");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again before the report");

  // unknown channels report zero speed and position
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !eps_pkg::ch_in_range(out_report_channel)
      |-> (out_speed_q16 == '0) && (out_position == '0))
    else $error("nonzero report for an unknown channel");

  // a tick accepted with a free output moves through S_WB into the output register
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == eps_pkg::CMD_TICK) && !out_valid
      |-> ##2 out_valid)
    else $error("tick report late");

endmodule

bind encoder_period_speed_meter eps_checker u_eps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .in_cmd             (in_chan.cmd),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_report_channel (out_chan.report_channel),
  .out_speed_q16      (out_chan.speed_q16),
  .out_position       (out_chan.position)
);

### tb/tb_encoder_period_speed_meter.sv
// ----------------------------------------------------------------------------
// tb_encoder_period_speed_meter
// self-checking bench for the encoder period speed meter: tick and edge
// transactions go in over valid/ready, a cycle-free predictor of the counters,
// positions and speeds builds the expected report of every transaction, and
// each report coming out is compared field by field in order. directed cases
// first, then random traffic under several idle/stall mixes and settings.
// ----------------------------------------------------------------------------
module tb_encoder_period_speed_meter;
  import eps_pkg::*;

  // report as it leaves the block, also used for the expected side
  typedef struct packed {
    logic [CH_FIELD_W-1:0]    ch;
    logic signed [SPEED_W-1:0] speed;
    logic signed [POS_W-1:0]   pos;
    logic [MASK_W-1:0]         mask;
  } speed_report_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  eps_in_if  in_bus ();
  eps_out_if out_bus ();

  encoder_period_speed_meter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predicted block state and registers
  logic [PERIOD_W-1:0]       pred_period_cnt [CHANNELS];
  logic [POS_W-1:0]          pred_position   [CHANNELS];
  logic signed [SPEED_W-1:0] pred_speed      [CHANNELS];
  logic [NUM_W-1:0]          pred_numerator;
  logic [PERIOD_W-1:0]       pred_timeout;

  // reports still owed by the block, oldest first
  speed_report_t expected_reports [$];

  int err_count;
  int send_idle_pct;
  int recv_stall_pct;

  // clock, period 4
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(4 * 2_000_000);
    $display("tb_encoder_period_speed_meter: done, errors");
    $finish;
  end

  // receiver side: ready drops at random with the current stall rate
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void clear_prediction();
    for (int c = 0; c < CHANNELS; c++) begin
      pred_period_cnt[c] = '0;
      pred_position[c]   = '0;
      pred_speed[c]      = '0;
    end
    pred_numerator = NUM_RESET;
    pred_timeout   = TIMEOUT_RESET;
  endfunction

  // advances the predicted state by one transaction and returns its report
  function automatic speed_report_t predict_report(input logic cmd,
                                                   input logic [CH_FIELD_W-1:0] ch,
                                                   input logic rev);
    speed_report_t             r;
    logic [PERIOD_W-1:0]       period;
    logic [NUM_W-1:0]          mag;
    logic signed [SPEED_W-1:0] smag;
    r    = '0;
    r.ch = ch;
    if (cmd == CMD_TICK) begin
      // every channel counts; one at or past the timeout wraps and stops
      for (int c = 0; c < CHANNELS; c++) begin
        if (pred_period_cnt[c] >= pred_timeout) begin
          pred_period_cnt[c] = '0;
          pred_speed[c]      = '0;
          if (c < MASK_W) r.mask[c] = 1'b1;
        end else begin
          pred_period_cnt[c] = pred_period_cnt[c] + 1'b1;
        end
      end
    end else if (ch < CHANNELS) begin
      period = pred_period_cnt[ch];
      // zero period saturates to the numerator itself
      mag  = (period == '0) ? pred_numerator : pred_numerator / period;
      smag = {1'b0, mag};
      pred_period_cnt[ch] = '0;
      if (rev) begin
        pred_speed[ch]    = -smag;
        pred_position[ch] = pred_position[ch] - 1'b1;
      end else begin
        pred_speed[ch]    = smag;
        pred_position[ch] = pred_position[ch] + 1'b1;
      end
    end
    // out of range channel reports zero speed and position
    if (ch < CHANNELS) begin
      r.speed = pred_speed[ch];
      r.pos   = pred_position[ch];
    end
    return r;
  endfunction

  // report checker: every accepted report against the oldest expectation
  always @(posedge clk) begin : report_check
    speed_report_t got;
    speed_report_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.ch    = out_bus.report_channel;
      got.speed = out_bus.speed_q16;
      got.pos   = out_bus.position;
      got.mask  = out_bus.stopped_mask;
      if (expected_reports.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected report: ch %0d speed %0d pos %0d mask %b",
                   got.ch, got.speed, got.pos, got.mask);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display({"report mismatch: exp ch %0d speed %0d pos %0d mask %b,",
                      " got ch %0d speed %0d pos %0d mask %b"},
                     want.ch, want.speed, want.pos, want.mask,
                     got.ch, got.speed, got.pos, got.mask);
        end
      end
    end
  end

  // one transaction; valid stays high across back-to-back transactions
  task automatic send_transaction(input logic cmd, input logic [CH_FIELD_W-1:0] ch,
                                  input logic rev);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_bus.valid             <= 1'b1;
    in_bus.cmd               <= cmd;
    in_bus.channel           <= ch;
    in_bus.direction_reverse <= rev;
    do @(posedge clk); while (!in_bus.ready);
    expected_reports.push_back(predict_report(cmd, ch, rev));
  endtask

  // stop sending, wait for every owed report, then let the divider settle
  task automatic wait_reports_drained();
    int guard;
    guard = 0;
    in_bus.valid <= 1'b0;
    while (expected_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (32) @(posedge clk);
  endtask

  // register write; only called while the block is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == CFG_NUMERATOR) pred_numerator = data[NUM_W-1:0];
    else                      pred_timeout   = data[PERIOD_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_zero_period();
    // first edge sees a cleared counter, so does the one right behind it
    send_transaction(CMD_EDGE, 2'd0, 1'b0);
    send_transaction(CMD_EDGE, 2'd0, 1'b0);
  endtask

  task automatic test_edge_periods();
    // three ticks, then edges divide by a period of three
    send_transaction(CMD_TICK, 2'd0, 1'b1);
    send_transaction(CMD_TICK, 2'd1, 1'b0);
    send_transaction(CMD_TICK, 2'd2, 1'b1);
    send_transaction(CMD_EDGE, 2'd1, 1'b1);
    send_transaction(CMD_EDGE, 2'd2, 1'b0);
  endtask

  task automatic test_channel_out_of_range();
    send_transaction(CMD_EDGE, 2'd3, 1'b1);
    send_transaction(CMD_TICK, 2'd3, 1'b0);
  endtask

  task automatic test_timeout_wrap();
    wait_reports_drained();
    write_register(CFG_TIMEOUT, 24'd2);
    repeat (3) send_transaction(CMD_TICK, 2'd0, 1'b0);
    // let counters climb, then drop the timeout below them
    wait_reports_drained();
    write_register(CFG_TIMEOUT, 24'd40);
    repeat (5) send_transaction(CMD_TICK, 2'd1, 1'b0);
    wait_reports_drained();
    write_register(CFG_TIMEOUT, 24'd1);
    send_transaction(CMD_TICK, 2'd2, 1'b0);
  endtask

  task automatic test_zero_timeout();
    wait_reports_drained();
    write_register(CFG_TIMEOUT, 24'd0);
    send_transaction(CMD_TICK, 2'd0, 1'b0);
    send_transaction(CMD_TICK, 2'd1, 1'b0);
  endtask

  task automatic test_numerator_extremes();
    wait_reports_drained();
    write_register(CFG_NUMERATOR, 24'hFFFFFF);
    write_register(CFG_TIMEOUT, 24'hFF_FFFF);
    // period one gives the full numerator, then the zero period reversed
    send_transaction(CMD_TICK, 2'd0, 1'b0);
    send_transaction(CMD_EDGE, 2'd0, 1'b0);
    send_transaction(CMD_EDGE, 2'd0, 1'b1);
    wait_reports_drained();
    write_register(CFG_NUMERATOR, 24'd0);
    send_transaction(CMD_TICK, 2'd1, 1'b1);
    send_transaction(CMD_EDGE, 2'd1, 1'b0);
  endtask

  // random register settings, extremes included; upper data bits are don't-care
  task automatic configure_random();
    int roll;
    logic [CFG_DATA_W-1:0] data;
    wait_reports_drained();
    roll = $urandom_range(0, 9);
    if (roll == 0)      data = '0;
    else if (roll == 1) data = 24'hFFFFFF;
    else if (roll == 2) data = NUM_RESET;
    else                data = $urandom_range(0, 24'hFFFFFF);
    write_register(CFG_NUMERATOR, data);
    data = $urandom_range(0, 24'hFFFFFF);
    roll = $urandom_range(0, 9);
    if (roll == 0)      data[PERIOD_W-1:0] = 16'hFFFF;
    else if (roll == 1) data[PERIOD_W-1:0] = 16'd1;
    else if (roll == 2) data[PERIOD_W-1:0] = 16'd0;
    else if (roll < 7)  data[PERIOD_W-1:0] = $urandom_range(1, 40);
    else                data[PERIOD_W-1:0] = $urandom_range(41, 400);
    write_register(CFG_TIMEOUT, data);
  endtask

  // random traffic: mostly ticks and in-range edges, a few out of range
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int roll;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    configure_random();
    for (int i = 0; i < count; i++) begin
      // mid-phase settings change, after a full pause of the sender
      if (i == count / 2) configure_random();
      roll = $urandom_range(0, 99);
      if (roll < 55)
        send_transaction(CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom));
      else if (roll < 95)
        send_transaction(CMD_EDGE, 2'($urandom_range(0, CHANNELS - 1)), 1'($urandom));
      else
        send_transaction(CMD_EDGE, 2'd3, 1'($urandom));
    end
  endtask

  initial begin
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = '0;
    cfg_wdata                = '0;
    in_bus.valid             = 1'b0;
    in_bus.cmd               = CMD_TICK;
    in_bus.channel           = '0;
    in_bus.direction_reverse = 1'b0;
    err_count                = 0;
    send_idle_pct            = 0;
    recv_stall_pct           = 0;
    clear_prediction();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, at reset settings first
    test_zero_period();
    test_edge_periods();
    test_channel_out_of_range();
    test_timeout_wrap();
    test_zero_timeout();
    test_numerator_extremes();

    // random part under each idle mix
    test_random_traffic(0, 0, 235);
    test_random_traffic(86, 0, 235);
    test_random_traffic(0, 86, 235);
    test_random_traffic(30, 30, 235);

    wait_reports_drained();
    // anything still owed never came out
    err_count += expected_reports.size();
    if (err_count == 0)
      $display("tb_encoder_period_speed_meter: done, clean");
    else
      $display("tb_encoder_period_speed_meter: done, errors");
    $finish;
  end

endmodule
